>>> src/ufrc_pkg.sv
// Shared types and constants of the disjoint-set engine.
package ufrc_pkg;

  // Width of the node fields on the ports.
  localparam int PORT_W = 10;

  // Rank storage and its saturation value.
  localparam int RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  // Step counter of the index reduction.
  localparam int RED_CNT_W = 4;

  // Operation codes.
  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_UNION = 1'b1;

  // Write enables towards the node tables.
  typedef struct packed {
    logic par_we;
    logic rank_we;
  } tbl_we_t;

  // One result beat.
  typedef struct packed {
    logic [PORT_W-1:0] root_a;
    logic [PORT_W-1:0] root_b;
    logic              already_joined;
  } result_t;

endpackage

>>> src/ufrc_table.sv
// Parent and rank memories with one shared registered read port.
module ufrc_table #(
  parameter int NODES = 1024,
  parameter int IDX_W = 10
) (
  input  logic                           clk_i,
  input  ufrc_pkg::tbl_we_t              we_i,
  input  logic [IDX_W-1:0]               par_waddr_i,
  input  logic [IDX_W-1:0]               par_wdata_i,
  input  logic [IDX_W-1:0]               rank_waddr_i,
  input  logic [ufrc_pkg::RANK_W-1:0]    rank_wdata_i,
  input  logic [IDX_W-1:0]               rd_addr_i,
  output logic [IDX_W-1:0]               par_rdata_o,
  output logic [ufrc_pkg::RANK_W-1:0]    rank_rdata_o
);

  logic [IDX_W-1:0]            par_mem  [NODES];
  logic [ufrc_pkg::RANK_W-1:0] rank_mem [NODES];
  logic [IDX_W-1:0]            par_rdata_q;
  logic [ufrc_pkg::RANK_W-1:0] rank_rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i.par_we) begin
      par_mem[par_waddr_i] <= par_wdata_i;
    end
    if (we_i.rank_we) begin
      rank_mem[rank_waddr_i] <= rank_wdata_i;
    end
    par_rdata_q  <= par_mem[rd_addr_i];
    rank_rdata_q <= rank_mem[rd_addr_i];
  end

  assign par_rdata_o  = par_rdata_q;
  assign rank_rdata_o = rank_rdata_q;

endmodule

>>> src/ufrc_seq.sv
// Sequencer: index reduction, root walk, path compression and linking.
module ufrc_seq #(
  parameter int NODES = 1024,
  parameter int IDX_W = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        ready_o,
  input  logic                        operation_i,
  input  logic [ufrc_pkg::PORT_W-1:0] node_a_i,
  input  logic [ufrc_pkg::PORT_W-1:0] node_b_i,
  output logic                        res_valid_o,
  input  logic                        res_take_i,
  output ufrc_pkg::result_t           res_o,
  output ufrc_pkg::tbl_we_t           we_o,
  output logic [IDX_W-1:0]            par_waddr_o,
  output logic [IDX_W-1:0]            par_wdata_o,
  output logic [IDX_W-1:0]            rank_waddr_o,
  output logic [ufrc_pkg::RANK_W-1:0] rank_wdata_o,
  output logic [IDX_W-1:0]            rd_addr_o,
  input  logic [IDX_W-1:0]            par_rdata_i,
  input  logic [ufrc_pkg::RANK_W-1:0] rank_rdata_i
);

  localparam int PW = ufrc_pkg::PORT_W;
  localparam int RW = ufrc_pkg::RANK_W;
  localparam int CW = ufrc_pkg::RED_CNT_W;
  // Number of compare-subtract steps that bring a port index below NODES.
  localparam int RED_STEPS = $clog2((1024 + NODES - 1) / NODES);
  localparam logic [PW-1:0] NODES_P = PW'(NODES);
  localparam logic [CW-1:0] RED_LAST = CW'(RED_STEPS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RED, S_START, S_WALK, S_COMP, S_FDONE, S_LINK, S_OUT
  } state_e;

  state_e            state_q;
  logic              op_q;
  logic              phase_b_q;
  logic [PW-1:0]     node_b_q;
  logic [PW-1:0]     red_q;
  logic [CW-1:0]     red_cnt_q;
  logic [IDX_W-1:0]  node_q;
  logic [IDX_W-1:0]  cur_q;
  logic [IDX_W-1:0]  root_q;
  logic [RW-1:0]     rank_root_q;
  logic [IDX_W-1:0]  ra_q;
  logic [IDX_W-1:0]  rb_q;
  logic [RW-1:0]     rank_a_q;
  logic [RW-1:0]     rank_b_q;
  logic              joined_q;
  logic [IDX_W-1:0]  clr_q;

  logic [PW-1:0]     red_div;
  logic [IDX_W-1:0]  red_node;
  logic              at_root;

  assign red_div  = NODES_P << red_cnt_q;
  assign red_node = IDX_W'(red_q);
  assign at_root  = (par_rdata_i == cur_q);

  // Memory control follows the state directly.
  always_comb begin
    we_o         = '0;
    par_waddr_o  = cur_q;
    par_wdata_o  = root_q;
    rank_waddr_o = ra_q;
    rank_wdata_o = rank_a_q;
    rd_addr_o    = cur_q;
    unique case (state_q)
      S_CLEAR: begin
        we_o.par_we  = 1'b1;
        we_o.rank_we = 1'b1;
        par_waddr_o  = clr_q;
        par_wdata_o  = clr_q;
        rank_waddr_o = clr_q;
        rank_wdata_o = '0;
      end
      S_START: begin
        rd_addr_o = red_node;
      end
      S_WALK: begin
        rd_addr_o = at_root ? node_q : par_rdata_i;
      end
      S_COMP: begin
        we_o.par_we = 1'b1;
        par_waddr_o = cur_q;
        par_wdata_o = root_q;
        rd_addr_o   = par_rdata_i;
      end
      S_LINK: begin
        if (!joined_q) begin
          we_o.par_we = 1'b1;
          if (rank_a_q < rank_b_q) begin
            par_waddr_o = ra_q;
            par_wdata_o = rb_q;
          end else begin
            par_waddr_o = rb_q;
            par_wdata_o = ra_q;
            if (rank_a_q == rank_b_q && rank_a_q != ufrc_pkg::RANK_MAX) begin
              we_o.rank_we = 1'b1;
              rank_waddr_o = ra_q;
              rank_wdata_o = rank_a_q + 4'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      phase_b_q <= 1'b0;
      op_q      <= ufrc_pkg::OP_FIND;
      joined_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LAST_IDX) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q      <= operation_i;
            node_b_q  <= node_b_i;
            red_q     <= node_a_i;
            red_cnt_q <= RED_LAST;
            phase_b_q <= 1'b0;
            state_q   <= (RED_STEPS == 0) ? S_START : S_RED;
          end
        end
        S_RED: begin
          if (red_q >= red_div) begin
            red_q <= red_q - red_div;
          end
          red_cnt_q <= red_cnt_q - 1'b1;
          if (red_cnt_q == '0) begin
            state_q <= S_START;
          end
        end
        S_START: begin
          node_q  <= red_node;
          cur_q   <= red_node;
          state_q <= S_WALK;
        end
        S_WALK: begin
          if (at_root) begin
            root_q      <= cur_q;
            rank_root_q <= rank_rdata_i;
            if (node_q == cur_q) begin
              state_q <= S_FDONE;
            end else begin
              cur_q   <= node_q;
              state_q <= S_COMP;
            end
          end else begin
            cur_q <= par_rdata_i;
          end
        end
        S_COMP: begin
          // The node whose parent is the root is the last one to rewrite.
          if (par_rdata_i == root_q) begin
            state_q <= S_FDONE;
          end else begin
            cur_q <= par_rdata_i;
          end
        end
        S_FDONE: begin
          if (!phase_b_q) begin
            ra_q     <= root_q;
            rank_a_q <= rank_root_q;
            if (op_q == ufrc_pkg::OP_UNION) begin
              phase_b_q <= 1'b1;
              red_q     <= node_b_q;
              red_cnt_q <= RED_LAST;
              state_q   <= (RED_STEPS == 0) ? S_START : S_RED;
            end else begin
              rb_q     <= '0;
              joined_q <= 1'b0;
              state_q  <= S_OUT;
            end
          end else begin
            rb_q     <= root_q;
            rank_b_q <= rank_root_q;
            joined_q <= (root_q == ra_q);
            state_q  <= S_LINK;
          end
        end
        S_LINK: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (res_take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign ready_o            = (state_q == S_IDLE);
  assign res_valid_o        = (state_q == S_OUT);
  assign res_o.root_a         = PW'(ra_q);
  assign res_o.root_b         = PW'(rb_q);
  assign res_o.already_joined = joined_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_o && in_valid_i) |=> !ready_o)
    else $error("sequencer still ready after taking an item");

  a_joined_same_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && joined_q) |-> (ra_q == rb_q))
    else $error("joined result with differing roots");

  a_find_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && op_q == ufrc_pkg::OP_FIND) |-> (rb_q == '0 && !joined_q))
    else $error("find result carries union fields");

  a_comp_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMP) |-> (rd_addr_o != par_waddr_o))
    else $error("compression reads the entry it rewrites");

  a_rank_bump_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_o.rank_we && state_q != S_CLEAR) |-> (rank_a_q == rank_b_q && !joined_q))
    else $error("rank raised on a link of unequal ranks");

endmodule

>>> src/union_find_rank_compress_top.sv
// Top level of the disjoint-set engine with its output register.
//
// Disjoint-set engine over NODES nodes (union by rank, path compression).
// After reset the block initialises every entry of its parent and rank
// memories and stalls input meanwhile. An item then occupies the sequencer
// for its index reduction steps (none when NODES is 1024 or more), the walk
// from the node up to its root and the compression that rewrites the nodes
// on that path (none for a root); a union adds the same steps for node_b and
// a link step. All of these steps are paced by the single read port shared
// by the parent and rank memories. With ranked linking chains stay near
// log2(NODES). A result waits in an output register, so the next item can
// be taken while the result beat is stalled.
module union_find_rank_compress_top #(
  parameter int NODES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [ufrc_pkg::PORT_W-1:0] node_a_i,
  input  logic [ufrc_pkg::PORT_W-1:0] node_b_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ufrc_pkg::PORT_W-1:0] root_a_o,
  output logic [ufrc_pkg::PORT_W-1:0] root_b_o,
  output logic                        already_joined_o
);

  localparam int IDX_W = $clog2(NODES);

  logic                        ready;
  logic                        res_valid;
  logic                        res_take;
  ufrc_pkg::result_t           res;
  ufrc_pkg::result_t           res_q;
  logic                        out_valid_q;
  ufrc_pkg::tbl_we_t           tbl_we;
  logic [IDX_W-1:0]            par_waddr;
  logic [IDX_W-1:0]            par_wdata;
  logic [IDX_W-1:0]            rank_waddr;
  logic [ufrc_pkg::RANK_W-1:0] rank_wdata;
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            par_rdata;
  logic [ufrc_pkg::RANK_W-1:0] rank_rdata;

  ufrc_seq #(
    .NODES (NODES),
    .IDX_W (IDX_W)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .ready_o      (ready),
    .operation_i  (operation_i),
    .node_a_i     (node_a_i),
    .node_b_i     (node_b_i),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res),
    .we_o         (tbl_we),
    .par_waddr_o  (par_waddr),
    .par_wdata_o  (par_wdata),
    .rank_waddr_o (rank_waddr),
    .rank_wdata_o (rank_wdata),
    .rd_addr_o    (rd_addr),
    .par_rdata_i  (par_rdata),
    .rank_rdata_i (rank_rdata)
  );

  ufrc_table #(
    .NODES (NODES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i        (clk_i),
    .we_i         (tbl_we),
    .par_waddr_i  (par_waddr),
    .par_wdata_i  (par_wdata),
    .rank_waddr_i (rank_waddr),
    .rank_wdata_i (rank_wdata),
    .rd_addr_i    (rd_addr),
    .par_rdata_o  (par_rdata),
    .rank_rdata_o (rank_rdata)
  );

  // The output register takes a new beat when empty or being drained.
  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      res_q <= res;
    end
  end

  assign in_stall_o       = !ready;
  assign out_valid_o      = out_valid_q;
  assign root_a_o         = res_q.root_a;
  assign root_b_o         = res_q.root_b;
  assign already_joined_o = res_q.already_joined;

endmodule

>>> bench/union_find_rank_compress_top_tb.sv
// Self-checking testbench of the disjoint-set engine: directed table, random traffic, predictor.
`timescale 1ns / 100ps

module union_find_rank_compress_top_tb;

  localparam int NODE_COUNT   = 1024;
  localparam int RANDOM_ITEMS = 1827;
  localparam int MAX_GAP      = 13;
  localparam int HOLD_AT_BEAT = 400;
  localparam int HOLD_CYCLES  = 1500;
  localparam int POOL_SPAN    = 64;

  typedef struct {
    logic                        op;
    logic [ufrc_pkg::PORT_W-1:0] a;
    logic [ufrc_pkg::PORT_W-1:0] b;
    bit                          typed;
    ufrc_pkg::result_t           res;
  } stim_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        operation_i;
  logic [ufrc_pkg::PORT_W-1:0] node_a_i;
  logic [ufrc_pkg::PORT_W-1:0] node_b_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [ufrc_pkg::PORT_W-1:0] root_a_o;
  logic [ufrc_pkg::PORT_W-1:0] root_b_o;
  logic                        already_joined_o;

  // Private copy of the forest, kept in step with every accepted beat.
  logic [ufrc_pkg::PORT_W-1:0] parent_of [NODE_COUNT];
  logic [ufrc_pkg::RANK_W-1:0] rank_of [NODE_COUNT];

  ufrc_pkg::result_t pending_roots[$];
  stim_row_t         directed_rows[$];
  int                mismatch_count;
  int                items_sent;
  int                beats_taken;

  union_find_rank_compress_top #(
    .NODES(NODE_COUNT)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .node_a_i        (node_a_i),
    .node_b_i        (node_b_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .root_a_o        (root_a_o),
    .root_b_o        (root_b_o),
    .already_joined_o(already_joined_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("union_find_rank_compress_top verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Walks to the root, then points every node on the walked path straight at it.
  function automatic logic [ufrc_pkg::PORT_W-1:0] root_with_compress(
      input logic [ufrc_pkg::PORT_W-1:0] node);
    logic [ufrc_pkg::PORT_W-1:0] root;
    logic [ufrc_pkg::PORT_W-1:0] next;
    int steps;
    root  = node;
    steps = 0;
    while (parent_of[root] != root && steps < NODE_COUNT) begin
      root = parent_of[root];
      steps++;
    end
    steps = 0;
    while (node != root && steps < NODE_COUNT) begin
      next            = parent_of[node];
      parent_of[node] = root;
      node            = next;
      steps++;
    end
    return root;
  endfunction

  function automatic ufrc_pkg::result_t dsu_resolve(input logic op,
                                                    input logic [ufrc_pkg::PORT_W-1:0] a,
                                                    input logic [ufrc_pkg::PORT_W-1:0] b);
    ufrc_pkg::result_t res;
    res        = '0;
    res.root_a = root_with_compress(a);
    if (op == ufrc_pkg::OP_UNION) begin
      res.root_b = root_with_compress(b);
      if (res.root_a == res.root_b) begin
        res.already_joined = 1'b1;
      end else if (rank_of[res.root_a] < rank_of[res.root_b]) begin
        parent_of[res.root_a] = res.root_b;
      end else if (rank_of[res.root_b] < rank_of[res.root_a]) begin
        parent_of[res.root_b] = res.root_a;
      end else begin
        // Equal ranks: the second root goes under the first, whose rank rises unless at RANK_MAX.
        parent_of[res.root_b] = res.root_a;
        if (rank_of[res.root_a] != ufrc_pkg::RANK_MAX) begin
          rank_of[res.root_a] = rank_of[res.root_a] + 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic add_row(input logic op, input int a, input int b, input bit typed,
                         input int ra, input int rb, input bit joined);
    stim_row_t row;
    row.op                 = op;
    row.a                  = ufrc_pkg::PORT_W'(a);
    row.b                  = ufrc_pkg::PORT_W'(b);
    row.typed              = typed;
    row.res.root_a         = ufrc_pkg::PORT_W'(ra);
    row.res.root_b         = ufrc_pkg::PORT_W'(rb);
    row.res.already_joined = joined;
    directed_rows          = {directed_rows, row};
  endtask

  // Offers one beat after a random gap or none, and records what it must produce once taken.
  task automatic offer_beat(input stim_row_t row);
    int gap;
    ufrc_pkg::result_t want;
    if ((items_sent / 64) % 5 == 4) begin
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= row.op;
    node_a_i    <= row.a;
    node_b_i    <= row.b;
    do @(posedge clk_i); while (in_stall_o);
    want = dsu_resolve(row.op, row.a, row.b);
    if (row.typed) begin
      want = row.res;
    end
    pending_roots = {pending_roots, want};
    items_sent++;
  endtask

  // Most picks fall in a small window so that trees grow tall enough to compress.
  function automatic logic [ufrc_pkg::PORT_W-1:0] pick_node(input int pool_base);
    if ($urandom_range(0, 9) < 7) begin
      return ufrc_pkg::PORT_W'(pool_base + $urandom_range(0, POOL_SPAN - 1));
    end
    return ufrc_pkg::PORT_W'($urandom_range(0, NODE_COUNT - 1));
  endfunction

  initial begin : stimulus
    stim_row_t row;
    int pool_base;
    int n;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = ufrc_pkg::OP_FIND;
    node_a_i       = '0;
    node_b_i       = '0;
    mismatch_count = 0;
    items_sent     = 0;
    for (n = 0; n < NODE_COUNT; n++) begin
      parent_of[n] = ufrc_pkg::PORT_W'(n);
      rank_of[n]   = '0;
    end

    add_row(ufrc_pkg::OP_FIND,  0,    0,    1, 0,    0,    0);
    add_row(ufrc_pkg::OP_FIND,  1023, 0,    1, 1023, 0,    0);
    add_row(ufrc_pkg::OP_FIND,  5,    1023, 1, 5,    0,    0);
    add_row(ufrc_pkg::OP_UNION, 0,    1023, 1, 0,    1023, 0);
    add_row(ufrc_pkg::OP_UNION, 1023, 0,    1, 0,    0,    1);
    add_row(ufrc_pkg::OP_FIND,  1023, 0,    1, 0,    0,    0);
    add_row(ufrc_pkg::OP_UNION, 3,    3,    1, 3,    3,    1);
    add_row(ufrc_pkg::OP_UNION, 341,  682,  1, 341,  682,  0);
    add_row(ufrc_pkg::OP_UNION, 682,  0,    0, 0,    0,    0);
    add_row(ufrc_pkg::OP_FIND,  1023, 0,    0, 0,    0,    0);
    add_row(ufrc_pkg::OP_UNION, 16,   17,   0, 0,    0,    0);
    add_row(ufrc_pkg::OP_UNION, 18,   19,   0, 0,    0,    0);
    add_row(ufrc_pkg::OP_UNION, 16,   18,   0, 0,    0,    0);
    add_row(ufrc_pkg::OP_UNION, 20,   21,   0, 0,    0,    0);
    add_row(ufrc_pkg::OP_UNION, 22,   23,   0, 0,    0,    0);
    add_row(ufrc_pkg::OP_UNION, 20,   22,   0, 0,    0,    0);
    add_row(ufrc_pkg::OP_UNION, 16,   20,   0, 0,    0,    0);
    add_row(ufrc_pkg::OP_FIND,  23,   512,  0, 0,    0,    0);
    add_row(ufrc_pkg::OP_UNION, 24,   16,   0, 0,    0,    0);
    add_row(ufrc_pkg::OP_FIND,  23,   0,    0, 0,    0,    0);
    add_row(ufrc_pkg::OP_UNION, 1023, 23,   0, 0,    0,    0);
    add_row(ufrc_pkg::OP_FIND,  1023, 0,    0, 0,    0,    0);
    add_row(ufrc_pkg::OP_FIND,  682,  0,    0, 0,    0,    0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_beat(directed_rows[i]);
    end

    pool_base = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 128 == 0) begin
        pool_base = $urandom_range(0, NODE_COUNT - POOL_SPAN);
      end
      row.op    = ($urandom_range(0, 99) < 60) ? ufrc_pkg::OP_UNION : ufrc_pkg::OP_FIND;
      row.a     = pick_node(pool_base);
      row.b     = pick_node(pool_base);
      row.typed = 1'b0;
      row.res   = '0;
      offer_beat(row);
    end
    in_valid_i <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("union_find_rank_compress_top verification clean");
    end else begin
      $display("union_find_rank_compress_top verification failed");
    end
    $finish;
  end

  // Result side: random stalls, bursts without stalls, and one long hold-off to back up the block.
  initial begin : result_sink
    int hold;
    out_stall_i = 1'b0;
    beats_taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (beats_taken == HOLD_AT_BEAT) begin
        hold = HOLD_CYCLES;
      end else if ((beats_taken / 80) % 4 == 2) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      beats_taken++;
    end
  end

  always @(posedge clk_i) begin : check_results
    ufrc_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("result beat arrived with nothing expected");
      end else begin
        want = pending_roots.pop_front();
        if (root_a_o !== want.root_a) begin
          report_mismatch($sformatf("root_a got %0d want %0d", root_a_o, want.root_a));
        end
        if (root_b_o !== want.root_b) begin
          report_mismatch($sformatf("root_b got %0d want %0d", root_b_o, want.root_b));
        end
        if (already_joined_o !== want.already_joined) begin
          report_mismatch($sformatf("already_joined got %0b want %0b",
                                    already_joined_o, want.already_joined));
        end
      end
    end
  end

endmodule

>>> sim.f
src/ufrc_pkg.sv
src/ufrc_table.sv
src/ufrc_seq.sv
src/union_find_rank_compress_top.sv
bench/union_find_rank_compress_top_tb.sv
